// ===== rtl/emspfm_pkg.sv =====
`timescale 1ns / 1ps

package emspfm_pkg;

	// Command codes
	localparam logic [1:0] CMD_REG_READ  = 2'd0;
	localparam logic [1:0] CMD_REG_WRITE = 2'd1;
	localparam logic [1:0] CMD_MEM_READ  = 2'd2;
	localparam logic [1:0] CMD_MEM_WRITE = 2'd3;

	localparam int unsigned FRAME_SLOTS = 4;
	localparam int unsigned SLOT_BITS   = $clog2(FRAME_SLOTS);
	localparam int unsigned NUM_REGS    = 2 * FRAME_SLOTS;
	localparam int unsigned REG_BITS    = $clog2(NUM_REGS);
	localparam int unsigned PAGE_BITS   = 5;

	// Pages at or above this limit do not enable a slot.
	localparam logic [6:0] PAGE_LIMIT = 7'd24;

	// Frame window 0xD0000..0xDFFFF, backing RAM at 0xA0000, 16 KiB pages.
	localparam logic [3:0] FRAME_SEG   = 4'hd;
	localparam logic [5:0] BACKING_PFN = 6'h28;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] port_addr;
		logic [19:0] mem_addr;
		logic [7:0]  data_in;
	} req_t;

	typedef struct packed {
		logic [7:0]  reg_value;
		logic        mapped;
		logic [19:0] phys_addr;
		logic        ram_write;
		logic [7:0]  ram_data;
	} rsp_t;

	// Mapping register write toward the register file
	typedef struct packed {
		logic                en;
		logic [REG_BITS-1:0] idx;
		logic [7:0]          data;
	} reg_wr_t;

	// Slot lookup result from the register file
	typedef struct packed {
		logic                 valid;
		logic [PAGE_BITS-1:0] page;
	} slot_t;

endpackage

// ===== rtl/emspfm_regfile.sv =====
`timescale 1ns / 1ps

module emspfm_regfile (
	input  logic                                clk,
	input  logic                                arst_n,
	input  emspfm_pkg::reg_wr_t                 wr,
	input  logic [emspfm_pkg::REG_BITS-1:0]     rd_idx,
	output logic [7:0]                          rd_data,
	input  logic [emspfm_pkg::SLOT_BITS-1:0]    slot_idx,
	output emspfm_pkg::slot_t                   slot
);

	logic [7:0]        map_regs_q [emspfm_pkg::NUM_REGS];
	emspfm_pkg::slot_t slots_q    [emspfm_pkg::FRAME_SLOTS];

	logic                                  wr_bank;
	logic [emspfm_pkg::SLOT_BITS-1:0]      wr_slot;
	emspfm_pkg::slot_t                     wr_entry;

	// Bank 1 adds 128 to the page, which is always past the limit.
	assign wr_bank = wr.idx[emspfm_pkg::REG_BITS-1];
	assign wr_slot = wr.idx[emspfm_pkg::SLOT_BITS-1:0];

	always_comb begin
		wr_entry.valid = wr.data[7] && !wr_bank && (wr.data[6:0] < emspfm_pkg::PAGE_LIMIT);
		wr_entry.page  = wr_entry.valid ? wr.data[emspfm_pkg::PAGE_BITS-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < emspfm_pkg::NUM_REGS; i++) begin
				map_regs_q[i] <= '0;
			end
			for (int i = 0; i < emspfm_pkg::FRAME_SLOTS; i++) begin
				slots_q[i] <= '0;
			end
		end else if (wr.en) begin
			map_regs_q[wr.idx] <= wr.data;
			slots_q[wr_slot]   <= wr_entry;
		end
	end

	assign rd_data = map_regs_q[rd_idx];
	assign slot    = slots_q[slot_idx];

endmodule

// ===== rtl/emspfm_xlate.sv =====
`timescale 1ns / 1ps

module emspfm_xlate (
	input  emspfm_pkg::req_t                    req,
	output logic [emspfm_pkg::REG_BITS-1:0]     rd_idx,
	input  logic [7:0]                          rd_data,
	output logic [emspfm_pkg::SLOT_BITS-1:0]    slot_idx,
	input  emspfm_pkg::slot_t                   slot,
	output emspfm_pkg::reg_wr_t                 wr,
	output emspfm_pkg::rsp_t                    rsp
);

	logic       frame_hit;
	logic       is_mem;
	logic [5:0] pfn;

	// Register index is {bit 4, bits 15:14}; bit 4 selects the bank.
	assign rd_idx   = {req.port_addr[4], req.port_addr[15:14]};
	assign slot_idx = req.mem_addr[15:14];

	assign wr.en   = (req.cmd == emspfm_pkg::CMD_REG_WRITE);
	assign wr.idx  = rd_idx;
	assign wr.data = req.data_in;

	assign is_mem    = (req.cmd == emspfm_pkg::CMD_MEM_READ) ||
	                   (req.cmd == emspfm_pkg::CMD_MEM_WRITE);
	assign frame_hit = is_mem && (req.mem_addr[19:16] == emspfm_pkg::FRAME_SEG) && slot.valid;
	assign pfn       = emspfm_pkg::BACKING_PFN + {1'b0, slot.page};

	always_comb begin
		rsp           = '0;
		rsp.reg_value = (req.cmd == emspfm_pkg::CMD_REG_READ) ? rd_data : 8'h00;
		if (frame_hit) begin
			rsp.mapped    = 1'b1;
			rsp.phys_addr = {pfn, req.mem_addr[13:0]};
			if (req.cmd == emspfm_pkg::CMD_MEM_WRITE) begin
				rsp.ram_write = 1'b1;
				rsp.ram_data  = req.data_in;
			end
		end
	end

endmodule

// ===== rtl/ems_page_frame_mapper.sv =====
`timescale 1ns / 1ps

// Expanded-memory page frame mapper. Each request carries one command: read
// or write one of eight byte-wide mapping registers (index from port bits
// 15:14 plus bit 4 as bank), or pass a memory read or write through the
// 64 KiB frame at 0xD0000. Writing a register with bit 7 set and a page below
// PAGE_LIMIT in bank 0 enables frame slot (index mod 4); any other write
// disables that slot. A memory access that hits an enabled slot comes back
// with mapped set and phys_addr = 0xA0000 + page * 0x4000 + offset; a miss
// returns all zero fields and the host drives 0xFF on a read miss. Every
// request yields exactly one response. Timing: one request per cycle
// sustained while rsp_ready stays high; a request passes one input register,
// the register file lookup and translation, then a response register that
// drives response valid, and waits in either register while the response
// side stalls. Register writes take effect for the very next request. The
// response register decouples the two sides; ready on the request side
// combinationally follows rsp_ready when both stages are full.
module ems_page_frame_mapper (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  emspfm_pkg::req_t   req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output emspfm_pkg::rsp_t   rsp
);

	logic                                  valid_s1;
	emspfm_pkg::req_t                      req_s1;
	logic                                  valid_s2;
	emspfm_pkg::rsp_t                      rsp_s2;

	logic                                  adv_s1;
	logic                                  adv_s2;
	logic [emspfm_pkg::REG_BITS-1:0]       rd_idx;
	logic [7:0]                            rd_data;
	logic [emspfm_pkg::SLOT_BITS-1:0]      slot_idx;
	emspfm_pkg::slot_t                     slot;
	emspfm_pkg::reg_wr_t                   wr_raw;
	emspfm_pkg::reg_wr_t                   wr;
	emspfm_pkg::rsp_t                      rsp_next;

	// Advance the response stage when it is empty or being drained.
	assign adv_s2    = !valid_s2 || rsp_ready;
	// Stage 1 moves on only into a free response slot.
	assign adv_s1    = valid_s1 && adv_s2;
	assign req_ready = !valid_s1 || adv_s2;

	// Input register: hold the request while the response side stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	emspfm_xlate u_xlate (
		.req      (req_s1),
		.rd_idx   (rd_idx),
		.rd_data  (rd_data),
		.slot_idx (slot_idx),
		.slot     (slot),
		.wr       (wr_raw),
		.rsp      (rsp_next)
	);

	// Commit a register write only when its request leaves stage 1, so a
	// stalled write is applied exactly once.
	always_comb begin
		wr    = wr_raw;
		wr.en = wr_raw.en && adv_s1;
	end

	emspfm_regfile u_regfile (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.rd_idx   (rd_idx),
		.rd_data  (rd_data),
		.slot_idx (slot_idx),
		.slot     (slot)
	);

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp_s2 <= rsp_next;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

`ifndef NO_ASSERTIONS
	// A RAM store is only ever issued for a translated access.
	a_write_needs_map: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.ram_write |-> rsp.mapped)
		else $error("ram_write without mapped");

	// Translated addresses always land in backing RAM at or above 0xA0000.
	a_phys_in_backing: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.mapped |-> rsp.phys_addr[19:16] >= 4'ha)
		else $error("translated address below backing RAM");

	// A register read result never carries memory side effects.
	a_reg_read_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.reg_value != 8'h00) |-> !rsp.mapped && !rsp.ram_write)
		else $error("register value mixed with memory response");

	// A request held in stage 1 reaches the response register once it frees.
	a_s1_drains: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 |=> valid_s2)
		else $error("stage 1 request lost");
`endif

endmodule

// ===== dv/ems_page_frame_mapper_checker.sv =====
`timescale 1ns / 1ps

module ems_page_frame_mapper_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_ready,
	input  emspfm_pkg::req_t  req,
	input  logic              rsp_valid,
	input  logic              rsp_ready,
	input  emspfm_pkg::rsp_t  rsp,
	output int unsigned       fail_count,
	output int unsigned       outstanding
);

	localparam int unsigned PAGE_SHIFT = 14;

	logic [7:0]                       map_bytes [emspfm_pkg::NUM_REGS];
	logic                             slot_on   [emspfm_pkg::FRAME_SLOTS];
	logic [emspfm_pkg::PAGE_BITS-1:0] slot_pfn  [emspfm_pkg::FRAME_SLOTS];

	emspfm_pkg::rsp_t expected_rsp [$];
	int unsigned      errors = 0;

	// Translate one request against the mirrored mapping state; update that state.
	function automatic emspfm_pkg::rsp_t translate_request(input emspfm_pkg::req_t r);
		emspfm_pkg::rsp_t                 o;
		logic [emspfm_pkg::REG_BITS-1:0]  idx;
		logic [emspfm_pkg::SLOT_BITS-1:0] slot;
		logic [7:0]                       page;
		o = '0;
		idx = {r.port_addr[4], r.port_addr[15:14]};
		unique case (r.cmd)
			emspfm_pkg::CMD_REG_READ: begin
				o.reg_value = map_bytes[idx];
			end
			emspfm_pkg::CMD_REG_WRITE: begin
				slot = idx[emspfm_pkg::SLOT_BITS-1:0];
				// bank bit lands on page bit 7, i.e. adds 128 pages
				page = {idx[emspfm_pkg::REG_BITS-1], r.data_in[6:0]};
				map_bytes[idx] = r.data_in;
				if (r.data_in[7] && page < emspfm_pkg::PAGE_LIMIT) begin
					slot_on[slot]  = 1'b1;
					slot_pfn[slot] = page[emspfm_pkg::PAGE_BITS-1:0];
				end else begin
					slot_on[slot]  = 1'b0;
					slot_pfn[slot] = '0;
				end
			end
			default: begin
				slot = r.mem_addr[PAGE_SHIFT +: emspfm_pkg::SLOT_BITS];
				if (r.mem_addr[19:16] == emspfm_pkg::FRAME_SEG && slot_on[slot]) begin
					o.mapped    = 1'b1;
					o.phys_addr = (20'(emspfm_pkg::BACKING_PFN) << PAGE_SHIFT)
						+ (20'(slot_pfn[slot]) << PAGE_SHIFT)
						+ 20'(r.mem_addr[PAGE_SHIFT-1:0]);
					if (r.cmd == emspfm_pkg::CMD_MEM_WRITE) begin
						o.ram_write = 1'b1;
						o.ram_data  = r.data_in;
					end
				end
			end
		endcase
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		emspfm_pkg::rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < emspfm_pkg::NUM_REGS; i++) map_bytes[i] = '0;
			for (int i = 0; i < emspfm_pkg::FRAME_SLOTS; i++) begin
				slot_on[i]  = 1'b0;
				slot_pfn[i] = '0;
			end
			expected_rsp.delete();
			outstanding <= 0;
			fail_count  <= errors;
		end else begin
			// compare first: a response never belongs to the request taken this edge
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp.size() == 0) begin
					$error("response with no request outstanding");
					errors++;
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.reg_value !== want.reg_value) begin
						$error("reg_value: expected %02h, got %02h", want.reg_value,
							rsp.reg_value);
						errors++;
					end
					if (rsp.mapped !== want.mapped) begin
						$error("mapped: expected %0b, got %0b", want.mapped, rsp.mapped);
						errors++;
					end
					if (rsp.phys_addr !== want.phys_addr) begin
						$error("phys_addr: expected %05h, got %05h", want.phys_addr,
							rsp.phys_addr);
						errors++;
					end
					if (rsp.ram_write !== want.ram_write) begin
						$error("ram_write: expected %0b, got %0b", want.ram_write,
							rsp.ram_write);
						errors++;
					end
					if (rsp.ram_data !== want.ram_data) begin
						$error("ram_data: expected %02h, got %02h", want.ram_data,
							rsp.ram_data);
						errors++;
					end
				end
			end
			if (req_valid && req_ready) expected_rsp.push_back(translate_request(req));
			outstanding <= expected_rsp.size();
			fail_count  <= errors;
		end
	end

endmodule

// ===== dv/ems_page_frame_mapper_test.sv =====
`timescale 1ns / 1ps

module ems_page_frame_mapper_test;

	localparam int unsigned RESET_CYCLES     = 11;
	localparam int unsigned RANDOM_PER_PHASE = 325;
	// two-stage pipe; keep watching after the drain to show any stray response
	localparam int unsigned DRAIN_CYCLES     = 8;
	// far above the slowest legal run of ~1350 requests at heavy idling
	localparam int unsigned CYCLE_LIMIT      = 200000;

	logic             clk;
	logic             arst_n    = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_ready;
	emspfm_pkg::req_t req       = '0;
	logic             rsp_valid;
	logic             rsp_ready = 1'b0;
	emspfm_pkg::rsp_t rsp;

	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned idle_pct  = 0;
	int unsigned stall_pct = 0;
	int unsigned cycles    = 0;

	ems_page_frame_mapper DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	ems_page_frame_mapper_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Throttle the response side; stall_pct is updated by NBA so the new
	// rate always takes effect on the following edge.
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Hard stop: a hung handshake ends the run here.
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("ems_page_frame_mapper: mismatch");
		$finish;
	end

	// Present one request and hold it until the mapper takes it. Valid stays
	// high across back-to-back requests; drop it only when an idle gap falls
	// in front of this request.
	task automatic send_request(input logic [1:0] cmd, input logic [15:0] port,
		input logic [19:0] addr, input logic [7:0] data);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct) gap++;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid     <= 1'b1;
		req.cmd       <= cmd;
		req.port_addr <= port;
		req.mem_addr  <= addr;
		req.data_in   <= data;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
	endtask

	// Random traffic biased toward useful mapping: most register writes go to
	// bank 0, most carry the enable bit and a page near or below the limit, and
	// most memory accesses land in the frame window. The rest is plain noise.
	task automatic run_random(input int unsigned count, input int unsigned idle,
		input int unsigned stall);
		logic [1:0]  cmd;
		logic [15:0] port;
		logic [19:0] addr;
		logic [7:0]  data;
		int unsigned pick;
		idle_pct = idle;
		stall_pct <= stall;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 25) cmd = emspfm_pkg::CMD_REG_READ;
			else if (pick < 50) cmd = emspfm_pkg::CMD_REG_WRITE;
			else if (pick < 75) cmd = emspfm_pkg::CMD_MEM_READ;
			else cmd = emspfm_pkg::CMD_MEM_WRITE;
			port = 16'($urandom);
			if ($urandom_range(99) < 70) port[4] = 1'b0;
			addr = 20'($urandom);
			if ($urandom_range(99) < 75) addr[19:16] = emspfm_pkg::FRAME_SEG;
			data = 8'($urandom);
			if (cmd == emspfm_pkg::CMD_REG_WRITE && $urandom_range(99) < 60)
				data = {1'b1, 7'($urandom_range(emspfm_pkg::PAGE_LIMIT + 3))};
			send_request(cmd, port, addr, data);
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: register 0 clear and slot 0 disabled out of reset
		send_request(emspfm_pkg::CMD_REG_READ,  16'h0000, 20'h00000, 8'h00);
		send_request(emspfm_pkg::CMD_MEM_READ,  16'h0000, 20'hd0000, 8'h00);
		// enable slot 0 at page 0, slot 1 at the last legal page, slot 3 at page 5;
		// slot 2 asks for the first page at the limit and stays off
		send_request(emspfm_pkg::CMD_REG_WRITE, 16'h0000, 20'h00000, 8'h80);
		send_request(emspfm_pkg::CMD_REG_WRITE, 16'h4000, 20'h00000, 8'h97);
		send_request(emspfm_pkg::CMD_REG_WRITE, 16'h8000, 20'h00000, 8'h98);
		send_request(emspfm_pkg::CMD_REG_WRITE, 16'hc000, 20'h00000, 8'h85);
		// only port bits 15:14 and 4 decode; the rest must be ignored
		send_request(emspfm_pkg::CMD_REG_READ,  16'h7fef, 20'hfffff, 8'hff);
		// hits at both frame edges; 0xD7FFF in slot 1 translates to the last RAM byte
		send_request(emspfm_pkg::CMD_MEM_READ,  16'h0000, 20'hd0000, 8'hff);
		send_request(emspfm_pkg::CMD_MEM_WRITE, 16'h0000, 20'hd7fff, 8'hff);
		send_request(emspfm_pkg::CMD_MEM_READ,  16'hffff, 20'hd8000, 8'h00);
		send_request(emspfm_pkg::CMD_MEM_WRITE, 16'h0000, 20'hdffff, 8'h5a);
		// frame misses just outside the window and at the address extremes
		send_request(emspfm_pkg::CMD_MEM_READ,  16'h0000, 20'hcffff, 8'h00);
		send_request(emspfm_pkg::CMD_MEM_WRITE, 16'h0000, 20'he0000, 8'ha5);
		send_request(emspfm_pkg::CMD_MEM_READ,  16'h0000, 20'h00000, 8'h00);
		send_request(emspfm_pkg::CMD_MEM_WRITE, 16'hffff, 20'hfffff, 8'hff);
		// a bank 1 write kills slot 0 even though bank 0 had enabled it
		send_request(emspfm_pkg::CMD_REG_WRITE, 16'h0010, 20'h00000, 8'h80);
		send_request(emspfm_pkg::CMD_MEM_READ,  16'h0000, 20'hd0000, 8'h00);
		send_request(emspfm_pkg::CMD_REG_READ,  16'h0010, 20'h00000, 8'h00);
		// enable bit clear disables slot 1 and zeroes its page
		send_request(emspfm_pkg::CMD_REG_WRITE, 16'h4000, 20'h00000, 8'h17);
		send_request(emspfm_pkg::CMD_MEM_WRITE, 16'h0000, 20'hd4000, 8'h3c);
		// all-ones byte into the last bank 1 register
		send_request(emspfm_pkg::CMD_REG_WRITE, 16'hffff, 20'h00000, 8'hff);
		send_request(emspfm_pkg::CMD_REG_READ,  16'hffff, 20'h00000, 8'h00);
		send_request(emspfm_pkg::CMD_MEM_READ,  16'h0000, 20'hdc000, 8'h00);
		send_request(emspfm_pkg::CMD_REG_WRITE, 16'h0000, 20'h00000, 8'h7f);

		// Random: full rate, slow sender, slow receiver, then both throttled
		run_random(RANDOM_PER_PHASE, 0, 0);
		run_random(RANDOM_PER_PHASE, 68, 0);
		run_random(RANDOM_PER_PHASE, 0, 68);
		run_random(RANDOM_PER_PHASE, 16, 16);
		req_valid <= 1'b0;

		// Drain: let the count pick up the last request, wait out every
		// response, then keep watching for strays
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && outstanding == 0) begin
			$display("ems_page_frame_mapper: match");
		end else begin
			$display("ems_page_frame_mapper: mismatch");
		end
		$finish;
	end

endmodule
